@@ rtl/arp_cache_with_aging_macros.svh @@
// ---------------------------------------------------------------------------
// ARP cache assertion macros
// Shorthand for the clocked checks at the end of the top level. They use the
// enclosing module's clk and rst.
// ---------------------------------------------------------------------------
`ifndef ARP_CACHE_WITH_AGING_MACROS_SVH
`define ARP_CACHE_WITH_AGING_MACROS_SVH

// same-cycle implication
`define ARPC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ARPC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/arpc_pkg.sv @@
// ---------------------------------------------------------------------------
// ARP cache package
// Field widths, register indexes, FSM states, entry layout and the
// controller/datapath command and status groups.
// ---------------------------------------------------------------------------
package arpc_pkg;

  localparam int IP_W     = 32;
  localparam int MAC_W    = 48;
  localparam int TICK_W   = 32;
  localparam int PLEN_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_IP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREFIX_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT  = 2'd2;

  localparam logic [PLEN_W-1:0] PREFIX_LEN_RST = 6'd24;
  localparam logic [TICK_W-1:0] AGE_LIMIT_RST  = 32'd120;
  localparam logic [PLEN_W-1:0] PREFIX_MAX     = 6'd32;

  localparam logic MODE_LEARN  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIRST,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [MAC_W-1:0]  mac;
    logic [TICK_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic load;    // take the accepted word
    logic first;   // read slot 0
    logic issue;   // read the next slot
    logic finish;  // resolve the scan, write back
    logic emit;    // move result to the output register
  } cmd_t;

  typedef struct packed {
    logic skip;      // learn outside the subnet
    logic stop;      // current slot ends the scan
    logic last;      // current slot is the last one
    logic out_free;  // output register can take a word
  } sts_t;

  // network mask for a prefix length, saturating at 32
  function automatic logic [IP_W-1:0] net_mask(input logic [PLEN_W-1:0] plen);
    logic [PLEN_W-1:0] len;
    len = (plen > PREFIX_MAX) ? PREFIX_MAX : plen;
    return ~({IP_W{1'b1}} >> len);
  endfunction

endpackage

@@ rtl/arpc_if.sv @@
// ---------------------------------------------------------------------------
// ARP cache channels
// Request channel (learn or lookup) and response channel, valid/ready.
// ---------------------------------------------------------------------------
interface arpc_req_if import arpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [TICK_W-1:0] now;
  logic [IP_W-1:0]   ip_addr;
  logic [MAC_W-1:0]  mac_addr;

  modport source (output valid, mode, now, ip_addr, mac_addr, input ready);
  modport sink   (input valid, mode, now, ip_addr, mac_addr, output ready);
endinterface

interface arpc_rsp_if import arpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [MAC_W-1:0] mac_out;
  logic             stored;

  modport source (output valid, hit, mac_out, stored, input ready);
  modport sink   (input valid, hit, mac_out, stored, output ready);
endinterface

@@ rtl/arpc_ctrl.sv @@
// ---------------------------------------------------------------------------
// ARP cache controller
// Sequences accept, slot scan, resolve and result hand-off.
// ---------------------------------------------------------------------------
module arpc_ctrl import arpc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = sts.skip ? S_DONE : S_FIRST;
        end
      end
      S_FIRST: state_next = S_SCAN;
      S_SCAN: begin
        if (sts.stop || sts.last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      S_FIRST: begin
        cmd.first = 1'b1;
        cmd.issue = 1'b1;
      end
      S_SCAN: begin
        cmd.issue  = 1'b1;
        cmd.finish = sts.stop || sts.last;
      end
      S_DONE: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ rtl/arpc_dp.sv @@
// ---------------------------------------------------------------------------
// ARP cache datapath
// Config registers, entry memory with valid bits, per-slot test and the
// result and output registers.
// ---------------------------------------------------------------------------
module arpc_dp import arpc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic                  req_mode,
  input  logic [TICK_W-1:0]     req_now,
  input  logic [IP_W-1:0]       req_ip,
  input  logic [MAC_W-1:0]      req_mac,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_hit,
  output logic [MAC_W-1:0]      out_mac,
  output logic                  out_stored
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

  logic [IP_W-1:0]   own_ip;
  logic [PLEN_W-1:0] prefix_len;
  logic [TICK_W-1:0] age_limit;

  logic              it_mode;
  logic [TICK_W-1:0] it_now;
  logic [IP_W-1:0]   it_ip;
  logic [MAC_W-1:0]  it_mac;

  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] valid;
  entry_t             rd_data;
  logic               rd_valid;
  logic [AW-1:0]      rd_addr, eval_addr;

  entry_t            cur, wr_data;
  logic [TICK_W-1:0] age;
  logic              fresh, ip_eq, learn_stop, lookup_stop, wr_en;

  logic             res_hit, res_stored;
  logic [MAC_W-1:0] res_mac;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip     <= '0;
      prefix_len <= PREFIX_LEN_RST;
      age_limit  <= AGE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OWN_IP:     own_ip     <= cfg_wdata[IP_W-1:0];
        REG_PREFIX_LEN: prefix_len <= cfg_wdata[PLEN_W-1:0];
        REG_AGE_LIMIT:  age_limit  <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign sts.skip = (req_mode == MODE_LEARN) &&
                    (((req_ip ^ own_ip) & net_mask(prefix_len)) != '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_mode <= req_mode;
      it_now  <= req_now;
      it_ip   <= req_ip;
      it_mac  <= req_mac;
    end
  end

  // slot 0 first, then the one after the slot under test
  assign rd_addr = cmd.first ? '0 : eval_addr + AW'(1);

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_data   <= mem[rd_addr];
      rd_valid  <= valid[rd_addr];
      eval_addr <= rd_addr;
    end
    if (wr_en) begin
      mem[eval_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[eval_addr] <= 1'b1;
    end
  end

  // never-written slots read as all zero (free)
  assign cur   = rd_valid ? rd_data : '0;
  assign age   = it_now - cur.stamp;
  assign fresh = age <= age_limit;
  assign ip_eq = cur.ip == it_ip;

  assign learn_stop  = (fresh && ip_eq) || (cur.stamp == '0) || !fresh;
  assign lookup_stop = ip_eq && fresh && (cur.mac != '0);

  assign sts.stop = (it_mode == MODE_LOOKUP) ? lookup_stop : learn_stop;
  assign sts.last = eval_addr == LAST_IDX;

  // refresh keeps the stored MAC; ip is equal there anyway
  assign wr_en         = cmd.finish && (it_mode == MODE_LEARN) && learn_stop;
  assign wr_data.ip    = it_ip;
  assign wr_data.mac   = (fresh && ip_eq) ? cur.mac : it_mac;
  assign wr_data.stamp = it_now;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_hit    <= 1'b0;
      res_mac    <= '0;
      res_stored <= 1'b0;
    end else if (cmd.finish) begin
      res_hit    <= (it_mode == MODE_LOOKUP) && lookup_stop;
      res_mac    <= ((it_mode == MODE_LOOKUP) && lookup_stop) ? cur.mac : '0;
      res_stored <= (it_mode == MODE_LEARN) && learn_stop;
    end
  end

  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_hit    <= res_hit;
      out_mac    <= res_mac;
      out_stored <= res_stored;
    end
  end

endmodule

@@ rtl/arp_cache_with_aging.sv @@
// ---------------------------------------------------------------------------
// ARP cache with aging
// IPv4-to-MAC cache of ENTRIES slots; each request word learns or looks up.
//
// req: mode (0 learn, 1 lookup), now, ip_addr, mac_addr; accepted on
//   valid && ready. ready is high only while no request is in flight.
// rsp: one word per request: hit, mac_out, stored.
// cfg: cfg_we / cfg_index / cfg_wdata write own_ip (0), prefix_len (1) and
//   age_limit (2); write only while idle.
// Timing: the scan reads one slot per cycle from the entry memory and stops
//   at the deciding slot. A request visits 1..ENTRIES slots; ready comes back
//   in the same cycle that its result enters the output register, so the next
//   request is not taken before then. An off-subnet learn skips the scan.
// Stall: the output register holds a word until rsp.ready; a finished scan
//   waits for that register, and the next request waits behind it.
// Reset (rst, synchronous): all slots read as free, registers take their
//   defaults (own_ip 0, prefix_len 24, age_limit 120); no clearing pass.
// ---------------------------------------------------------------------------
`include "arp_cache_with_aging_macros.svh"

module arp_cache_with_aging import arpc_pkg::*; #(
  parameter int ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  arpc_req_if.sink              req,
  arpc_rsp_if.source            rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  arpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  arpc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_mode   (req.mode),
    .req_now    (req.now),
    .req_ip     (req.ip_addr),
    .req_mac    (req.mac_addr),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (rsp.valid),
    .out_ready  (rsp.ready),
    .out_hit    (rsp.hit),
    .out_mac    (rsp.mac_out),
    .out_stored (rsp.stored)
  );

  `ARPC_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready after accept")
  `ARPC_ASSERT_NOW(a_hit_xor_stored, rsp.valid, !(rsp.hit && rsp.stored), "hit and stored")
  `ARPC_ASSERT_NOW(a_miss_mac_zero, rsp.valid && !rsp.hit, rsp.mac_out == '0, "mac on miss")

endmodule
